// ===== hw/rtl/nnm_pkg.sv =====
// nnm_pkg: widths, constants and payload types of the normalized normal matrix unit
// no dependencies; used by every module of the unit
package nnm_pkg;

    localparam int ELEM_WIDTH_DEF = 32;   // default significant bits of an input element
    localparam int ELEM_BITS      = 32;   // width of an input field
    localparam int OUT_BITS       = 32;   // width of an output normal element
    localparam int N_COF          = 9;
    localparam int N_PROD         = 2 * N_COF;
    localparam int COF_BITS       = 64;
    localparam int HALF_BITS      = COF_BITS / 2;
    localparam int FRAC_OUT       = 30;
    localparam int Q_BITS         = FRAC_OUT + 1;   // quotient is at most 2^30
    localparam int DIV_STEPS      = Q_BITS;
    localparam int PPROD_BITS     = ELEM_BITS + HALF_BITS;      // one partial product
    localparam int DPROD_BITS     = ELEM_BITS + COF_BITS + 1;   // signed a * cofactor
    localparam int DET_BITS       = DPROD_BITS + 2;

    typedef struct packed {
        logic signed [ELEM_BITS-1:0] c0_r0;
        logic signed [ELEM_BITS-1:0] c0_r1;
        logic signed [ELEM_BITS-1:0] c0_r2;
        logic signed [ELEM_BITS-1:0] c1_r0;
        logic signed [ELEM_BITS-1:0] c1_r1;
        logic signed [ELEM_BITS-1:0] c1_r2;
        logic signed [ELEM_BITS-1:0] c2_r0;
        logic signed [ELEM_BITS-1:0] c2_r1;
        logic signed [ELEM_BITS-1:0] c2_r2;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] n0_x;
        logic signed [OUT_BITS-1:0] n0_y;
        logic signed [OUT_BITS-1:0] n0_z;
        logic signed [OUT_BITS-1:0] n1_x;
        logic signed [OUT_BITS-1:0] n1_y;
        logic signed [OUT_BITS-1:0] n1_z;
        logic signed [OUT_BITS-1:0] n2_x;
        logic signed [OUT_BITS-1:0] n2_y;
        logic signed [OUT_BITS-1:0] n2_z;
        logic                       mirrored;
    } t_out_item;

    // cofactors and the first column, leaving the cofactor stages
    typedef struct packed {
        logic [N_COF-1:0][COF_BITS-1:0] cof;
        logic [2:0][ELEM_BITS-1:0]      col0;
    } t_cof_data;

    // state of the nine lane restoring divider
    typedef struct packed {
        logic [N_COF-1:0][COF_BITS-1:0] rem;
        logic [N_COF-1:0][Q_BITS-1:0]   quo;
        logic [COF_BITS-1:0]            den;
        logic [N_COF-1:0]               flip;
        logic                           zero;
        logic                           mirrored;
    } t_div_data;

endpackage

// ===== hw/rtl/nnm_stream_if.sv =====
// nnm_stream_if: valid/ready stream channel with a typed payload
// no dependencies; payload types come from nnm_pkg at the instantiation
interface nnm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/normalized_normal_matrix_unit.sv =====
// normalized_normal_matrix_unit: top level of the cofactor normal matrix pipeline
// depends on nnm_pkg, nnm_stream_if, nnm_cofactor, nnm_reduce, nnm_div_step

// One 3x3 matrix (nine Q16.16 elements, column-major) can be transferred in
// every cycle while the pipeline does not hold, and one normal matrix (nine
// Q2.30 elements plus the mirrored flag) leaves per matrix, in order. Each
// result passes 39 register stages: two cofactor stages, five stages for
// magnitudes, determinant sign and the largest magnitude, 31 restoring
// division steps (one quotient bit per stage, nine lanes in parallel) and
// the output register. The whole pipeline advances together; it holds when
// the output register is full and not taken, so the input is ready whenever
// the output is empty or being transferred. Only the low ELEM_WIDTH bits of
// each input element count, sign extended.
module normalized_normal_matrix_unit #(
    parameter int ELEM_WIDTH = nnm_pkg::ELEM_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nnm_stream_if.sink   i_in,
    nnm_stream_if.source o_out
);
    localparam int NS = nnm_pkg::DIV_STEPS;
    localparam int OB = nnm_pkg::OUT_BITS;

    // global advance: the output register is free or drains this cycle
    logic en;

    logic               cof_valid;
    nnm_pkg::t_cof_data cof_data;

    // divider chain: index 0 is the start state from the reduce stages
    logic               div_valid [NS+1];
    nnm_pkg::t_div_data div_data  [NS+1];

    logic               r_out_valid;
    nnm_pkg::t_out_item r_out;
    logic [OB-1:0]      s_val [nnm_pkg::N_COF];

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    nnm_cofactor #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .o_valid (cof_valid),
        .o_data  (cof_data)
    );

    nnm_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cof_valid),
        .i_data  (cof_data),
        .o_valid (div_valid[0]),
        .o_data  (div_data[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_div
        nnm_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_valid[g]),
            .i_data  (div_data[g]),
            .o_valid (div_valid[g+1]),
            .o_data  (div_data[g+1])
        );
    end

    // apply the sign, zero everything when all cofactors vanish
    always_comb begin
        for (int k = 0; k < nnm_pkg::N_COF; k++) begin
            if (div_data[NS].zero) begin
                s_val[k] = '0;
            end else if (div_data[NS].flip[k]) begin
                s_val[k] = OB'(0) - OB'(div_data[NS].quo[k]);
            end else begin
                s_val[k] = OB'(div_data[NS].quo[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.n0_x     <= s_val[0];
            r_out.n0_y     <= s_val[1];
            r_out.n0_z     <= s_val[2];
            r_out.n1_x     <= s_val[3];
            r_out.n1_y     <= s_val[4];
            r_out.n1_z     <= s_val[5];
            r_out.n2_x     <= s_val[6];
            r_out.n2_y     <= s_val[7];
            r_out.n2_z     <= s_val[8];
            r_out.mirrored <= div_data[NS].mirrored;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

// ===== hw/rtl/nnm_cofactor.sv =====
// nnm_cofactor: two stages, 18 element products then nine cofactor differences
// depends on nnm_pkg
module nnm_cofactor #(
    parameter int ELEM_WIDTH = nnm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  nnm_pkg::t_in_item   i_item,
    output logic                o_valid,
    output nnm_pkg::t_cof_data  o_data
);
    localparam int EB = nnm_pkg::ELEM_BITS;
    localparam int CB = nnm_pkg::COF_BITS;

    logic signed [EB-1:0] a [3];
    logic signed [EB-1:0] b [3];
    logic signed [EB-1:0] c [3];
    logic signed [EB-1:0] x [nnm_pkg::N_PROD];
    logic signed [EB-1:0] y [nnm_pkg::N_PROD];

    logic signed [CB-1:0] r_prod [nnm_pkg::N_PROD];
    logic [2:0][EB-1:0]   r_col0;
    logic                 r_v1;
    logic                 r_v2;
    nnm_pkg::t_cof_data   r_out;

    // keep only the low ELEM_WIDTH bits, sign extended
    function automatic logic signed [EB-1:0] sext(input logic [EB-1:0] v);
        logic signed [ELEM_WIDTH-1:0] t;
        t = signed'(v[ELEM_WIDTH-1:0]);
        return EB'(t);
    endfunction

    always_comb begin
        a[0] = sext(i_item.c0_r0); a[1] = sext(i_item.c0_r1); a[2] = sext(i_item.c0_r2);
        b[0] = sext(i_item.c1_r0); b[1] = sext(i_item.c1_r1); b[2] = sext(i_item.c1_r2);
        c[0] = sext(i_item.c2_r0); c[1] = sext(i_item.c2_r1); c[2] = sext(i_item.c2_r2);
        // cofactor k = x[2k]*y[2k] - x[2k+1]*y[2k+1]
        x[0]  = b[1]; y[0]  = c[2]; x[1]  = b[2]; y[1]  = c[1];
        x[2]  = b[2]; y[2]  = c[0]; x[3]  = b[0]; y[3]  = c[2];
        x[4]  = b[0]; y[4]  = c[1]; x[5]  = b[1]; y[5]  = c[0];
        x[6]  = c[1]; y[6]  = a[2]; x[7]  = c[2]; y[7]  = a[1];
        x[8]  = c[2]; y[8]  = a[0]; x[9]  = c[0]; y[9]  = a[2];
        x[10] = c[0]; y[10] = a[1]; x[11] = c[1]; y[11] = a[0];
        x[12] = a[1]; y[12] = b[2]; x[13] = a[2]; y[13] = b[1];
        x[14] = a[2]; y[14] = b[0]; x[15] = a[0]; y[15] = b[2];
        x[16] = a[0]; y[16] = b[1]; x[17] = a[1]; y[17] = b[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < nnm_pkg::N_PROD; i++) begin
                r_prod[i] <= CB'(x[i]) * CB'(y[i]);
            end
            for (int j = 0; j < 3; j++) begin
                r_col0[j] <= a[j];
            end
            // differences wrap at cofactor width
            for (int k = 0; k < nnm_pkg::N_COF; k++) begin
                r_out.cof[k] <= r_prod[2*k] - r_prod[2*k+1];
            end
            r_out.col0 <= r_col0;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_out;
endmodule

// ===== hw/rtl/nnm_reduce.sv =====
// nnm_reduce: five stages of magnitudes, determinant sign and largest magnitude
// depends on nnm_pkg; produces the divider's starting state
module nnm_reduce (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  nnm_pkg::t_cof_data  i_data,
    output logic                o_valid,
    output nnm_pkg::t_div_data  o_data
);
    localparam int CB = nnm_pkg::COF_BITS;
    localparam int HB = nnm_pkg::HALF_BITS;
    localparam int EB = nnm_pkg::ELEM_BITS;
    localparam int NC = nnm_pkg::N_COF;
    localparam int PB = nnm_pkg::PPROD_BITS;
    localparam int DB = nnm_pkg::DPROD_BITS;
    localparam int TB = nnm_pkg::DET_BITS;

    typedef logic [NC-1:0][CB-1:0] t_mags;

    logic [4:0] r_v;

    t_mags          r3_mag, r4_mag, r5_mag, r6_mag;
    logic [NC-1:0]  r3_sgn, r4_sgn, r5_sgn, r6_sgn;
    logic [EB-1:0]  r3_ua [3];
    logic [2:0]     r3_asg;
    logic [PB-1:0]  r4_p0 [3];
    logic [PB-1:0]  r4_p1 [3];
    logic [2:0]     r4_ps;
    logic [CB-1:0]  r4_m [5];
    logic [DB-1:0]  r5_prod [3];
    logic [CB-1:0]  r5_m [3];
    logic           r6_neg;
    logic [CB-1:0]  r6_m [2];
    nnm_pkg::t_div_data r_out;

    logic [DB-2:0]  s_sum [3];
    logic [TB-1:0]  s_det;
    logic [CB-1:0]  s_max;

    function automatic logic [CB-1:0] max_u(input logic [CB-1:0] p, input logic [CB-1:0] q);
        return (p > q) ? p : q;
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_sum[i] = {r4_p1[i], {HB{1'b0}}} + (DB-1)'(r4_p0[i]);
        end
        s_det = TB'(signed'(r5_prod[0])) + TB'(signed'(r5_prod[1]))
              + TB'(signed'(r5_prod[2]));
        s_max = max_u(r6_m[0], r6_m[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // magnitudes and signs
            for (int k = 0; k < NC; k++) begin
                r3_sgn[k] <= i_data.cof[k][CB-1];
                r3_mag[k] <= i_data.cof[k][CB-1] ? CB'(0) - i_data.cof[k] : i_data.cof[k];
            end
            for (int j = 0; j < 3; j++) begin
                r3_asg[j] <= i_data.col0[j][EB-1];
                r3_ua[j]  <= i_data.col0[j][EB-1] ? EB'(0) - i_data.col0[j] : i_data.col0[j];
            end
            // partial products of the determinant, first max level
            for (int j = 0; j < 3; j++) begin
                r4_p0[j] <= PB'(r3_ua[j]) * PB'(r3_mag[j][HB-1:0]);
                r4_p1[j] <= PB'(r3_ua[j]) * PB'(r3_mag[j][CB-1:HB]);
                r4_ps[j] <= r3_asg[j] ^ r3_sgn[j];
            end
            for (int m = 0; m < 4; m++) begin
                r4_m[m] <= max_u(r3_mag[2*m], r3_mag[2*m+1]);
            end
            r4_m[4] <= r3_mag[8];
            r4_mag  <= r3_mag;
            r4_sgn  <= r3_sgn;
            // signed products, second max level
            for (int j = 0; j < 3; j++) begin
                r5_prod[j] <= r4_ps[j] ? DB'(0) - {1'b0, s_sum[j]} : {1'b0, s_sum[j]};
            end
            r5_m[0] <= max_u(r4_m[0], r4_m[1]);
            r5_m[1] <= max_u(r4_m[2], r4_m[3]);
            r5_m[2] <= r4_m[4];
            r5_mag  <= r4_mag;
            r5_sgn  <= r4_sgn;
            // determinant sign, third max level
            r6_neg  <= s_det[TB-1];
            r6_m[0] <= max_u(r5_m[0], r5_m[1]);
            r6_m[1] <= r5_m[2];
            r6_mag  <= r5_mag;
            r6_sgn  <= r5_sgn;
            // divider start
            r_out.rem      <= r6_mag;
            r_out.quo      <= '0;
            r_out.den      <= s_max;
            r_out.flip     <= r6_sgn ^ {NC{r6_neg}};
            r_out.zero     <= (s_max == '0);
            r_out.mirrored <= r6_neg;
        end
    end

    assign o_valid = r_v[4];
    assign o_data  = r_out;
endmodule

// ===== hw/rtl/nnm_div_step.sv =====
// nnm_div_step: one restoring division step on all nine lanes, registered
// depends on nnm_pkg
module nnm_div_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  nnm_pkg::t_div_data  i_data,
    output logic                o_valid,
    output nnm_pkg::t_div_data  o_data
);
    localparam int CB = nnm_pkg::COF_BITS;
    localparam int QB = nnm_pkg::Q_BITS;

    logic               r_valid;
    nnm_pkg::t_div_data r_data;
    nnm_pkg::t_div_data n_data;
    logic [CB-1:0]      s_keep;

    // remainder stays below the divisor, so the shift never loses a bit
    always_comb begin
        n_data = i_data;
        s_keep = '0;
        for (int k = 0; k < nnm_pkg::N_COF; k++) begin
            if (i_data.rem[k] >= i_data.den) begin
                s_keep = i_data.rem[k] - i_data.den;
                n_data.quo[k] = {i_data.quo[k][QB-2:0], 1'b1};
            end else begin
                s_keep = i_data.rem[k];
                n_data.quo[k] = {i_data.quo[k][QB-2:0], 1'b0};
            end
            n_data.rem[k] = {s_keep[CB-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
